[rtl/deferred_free_index_allocator_unit_macros.svh]
// ----------------------------------------------------------------------------
// Assertion macros for the deferred free index allocator
// Concurrent check wrappers clocked by clk and disabled while rst_n is low.
// ----------------------------------------------------------------------------
`ifndef DEFERRED_FREE_INDEX_ALLOCATOR_UNIT_MACROS_SVH
`define DEFERRED_FREE_INDEX_ALLOCATOR_UNIT_MACROS_SVH

`ifndef ASSERT_OFF
// A condition that must hold at every clock edge outside reset.
`define DFIA_ASSERT_ALWAYS(lbl, cond, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);
// An antecedent that implies a consequent in the next cycle.
`define DFIA_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);
// An antecedent that implies a consequent in the same cycle.
`define DFIA_ASSERT_IMPL(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);
`else
`define DFIA_ASSERT_ALWAYS(lbl, cond, msg)
`define DFIA_ASSERT_NEXT(lbl, ante, cons, msg)
`define DFIA_ASSERT_IMPL(lbl, ante, cons, msg)
`endif

`endif

[rtl/dfia_pkg.sv]
// ----------------------------------------------------------------------------
// dfia_pkg
// Shared types, codes and constants of the deferred free index allocator.
// ----------------------------------------------------------------------------
package dfia_pkg;

    localparam int NUM_HEAPS_DEF = 4;
    localparam int MAX_DESC_DEF  = 1024;

    localparam int IDX_W      = 10;
    localparam int CNT_OUT_W  = 11;
    localparam int HEAP_W     = 2;
    localparam int REQ_W      = 2;
    localparam int STATUS_W   = 3;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 11;

    typedef enum logic [REQ_W-1:0] {
        REQ_ALLOC   = 2'd0,
        REQ_RELEASE = 2'd1,
        REQ_FLUSH   = 2'd2
    } req_code_t;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK        = 3'd0,
        ST_ABSENT    = 3'd1,
        ST_EMPTY     = 3'd2,
        ST_PEND_FULL = 3'd3,
        ST_OVERFLOW  = 3'd4
    } status_t;

    typedef struct packed {
        logic [REQ_W-1:0]  req_type;
        logic [HEAP_W-1:0] heap_type;
        logic [IDX_W-1:0]  release_index;
    } req_t;

    typedef struct packed {
        logic [STATUS_W-1:0]  status;
        logic [IDX_W-1:0]     alloc_index;
        logic [CNT_OUT_W-1:0] free_count;
    } rsp_t;

    // Updates applied to the selected heap's bookkeeping registers.
    typedef struct packed {
        logic top_dec;
        logic top_inc;
        logic pcnt_inc;
        logic pcnt_clr;
    } heap_op_t;

endpackage

[rtl/deferred_free_index_allocator_unit.sv]
// ----------------------------------------------------------------------------
// deferred_free_index_allocator_unit
// Free list index allocator with deferred free for several descriptor heaps.
// ----------------------------------------------------------------------------
// Usage:
//   req carries one request beat (allocate, release or flush) on req_valid /
//   req_ready; rsp returns exactly one result beat per request on rsp_valid /
//   rsp_ready. cfg_we writes a heap size register; a write sets
//   up the whole free stack at once through a fill mark, so there is no sweep.
//   Allocate and release issue the free stack read or the pending write at
//   the accept edge; the result register is loaded from S_RESP once it is free.
//   A flush walks every heap and moves each pending entry that fits with a
//   pending RAM read, then a free stack RAM write, before the result is loaded.
//   One request is in flight at a time; req_ready is high while the control
//   is idle, also while a finished result still waits in the output register.
//   A stalled receiver holds the result register and the next result waits
//   in the control until it drains.
//   Reset clears all heap sizes and counters; both RAMs need no clearing.
// ----------------------------------------------------------------------------
`include "deferred_free_index_allocator_unit_macros.svh"

module deferred_free_index_allocator_unit #(
    parameter int NUM_HEAPS = dfia_pkg::NUM_HEAPS_DEF,
    parameter int MAX_DESC  = dfia_pkg::MAX_DESC_DEF
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            cfg_we,
    input  logic [dfia_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [dfia_pkg::CFG_DATA_W-1:0] cfg_data,
    input  logic                            req_valid,
    output logic                            req_ready,
    input  dfia_pkg::req_t                  req,
    output logic                            rsp_valid,
    input  logic                            rsp_ready,
    output dfia_pkg::rsp_t                  rsp
);

    import dfia_pkg::*;

    localparam int HW        = (NUM_HEAPS > 1) ? $clog2(NUM_HEAPS) : 1;
    localparam int CNT_W     = $clog2(MAX_DESC + 1);
    localparam int POS_W     = $clog2(MAX_DESC);
    localparam int MEM_DEPTH = NUM_HEAPS << POS_W;
    localparam int MEM_AW    = $clog2(MEM_DEPTH);

    typedef enum logic [3:0] {
        S_IDLE  = 4'b0001,
        S_RESP  = 4'b0010,
        S_FL_RD = 4'b0100,
        S_FL_WR = 4'b1000
    } state_t;

    state_t             state_reg, state_next;
    logic [HEAP_W-1:0]  h_reg, h_next;
    status_t            status_reg, status_next;
    logic               alloc_ok_reg, alloc_ok_next;
    logic               use_mem_reg, use_mem_next;
    logic [POS_W-1:0]   pos_reg, pos_next;
    logic [HW-1:0]      k_reg, k_next;
    logic [CNT_W-1:0]   i_reg, i_next;
    logic               ovf_reg, ovf_next;
    logic               rsp_valid_reg, rsp_valid_next;
    rsp_t               rsp_reg, rsp_next;

    logic [HW-1:0]      sel_heap;
    logic               sel_ok;
    heap_op_t           op;
    logic               present;
    logic [CNT_W-1:0]   top;
    logic [CNT_W-1:0]   lo;
    logic [CNT_W-1:0]   pcnt;
    logic               top_full;
    logic               pend_full;
    logic [CNT_W-1:0]   top_m1;

    logic               fs_we, fs_re;
    logic [MEM_AW-1:0]  fs_waddr, fs_raddr;
    logic [IDX_W-1:0]   fs_wdata, fs_rdata;
    logic               pd_we, pd_re;
    logic [MEM_AW-1:0]  pd_waddr, pd_raddr;
    logic [IDX_W-1:0]   pd_rdata;

    logic               heap_done;
    logic               ovf_hit;

    dfia_heap_tbl #(
        .NUM_HEAPS (NUM_HEAPS),
        .MAX_DESC  (MAX_DESC)
    ) u_heap_tbl (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .sel_heap  (sel_heap),
        .sel_ok    (sel_ok),
        .op        (op),
        .present   (present),
        .top       (top),
        .lo        (lo),
        .pcnt      (pcnt)
    );

    dfia_ram #(
        .WIDTH (IDX_W),
        .DEPTH (MEM_DEPTH)
    ) u_free_ram (
        .clk   (clk),
        .we    (fs_we),
        .waddr (fs_waddr),
        .wdata (fs_wdata),
        .re    (fs_re),
        .raddr (fs_raddr),
        .rdata (fs_rdata)
    );

    dfia_ram #(
        .WIDTH (IDX_W),
        .DEPTH (MEM_DEPTH)
    ) u_pend_ram (
        .clk   (clk),
        .we    (pd_we),
        .waddr (pd_waddr),
        .wdata (req.release_index),
        .re    (pd_re),
        .raddr (pd_raddr),
        .rdata (pd_rdata)
    );

    assign req_ready = (state_reg == S_IDLE);
    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

    assign top_full  = (32'(top) >= MAX_DESC);
    assign pend_full = (32'(pcnt) >= MAX_DESC);
    assign top_m1    = top - CNT_W'(1);
    assign heap_done = !present || (i_reg >= pcnt) || top_full;
    assign ovf_hit   = present && (i_reg < pcnt) && top_full;

    // The heap table has a single read port; its address follows the state.
    always_comb
    begin
        unique case (state_reg) inside
            S_IDLE:
            begin
                sel_heap = HW'(req.heap_type);
                sel_ok   = (32'(req.heap_type) < NUM_HEAPS);
            end
            S_RESP:
            begin
                sel_heap = HW'(h_reg);
                sel_ok   = (32'(h_reg) < NUM_HEAPS);
            end
            S_FL_RD, S_FL_WR:
            begin
                sel_heap = k_reg;
                sel_ok   = 1'b1;
            end
            default:
            begin
                sel_heap = '0;
                sel_ok   = 1'b0;
            end
        endcase
    end

    always_comb
    begin
        state_next     = state_reg;
        h_next         = h_reg;
        status_next    = status_reg;
        alloc_ok_next  = alloc_ok_reg;
        use_mem_next   = use_mem_reg;
        pos_next       = pos_reg;
        k_next         = k_reg;
        i_next         = i_reg;
        ovf_next       = ovf_reg;
        rsp_valid_next = rsp_valid_reg && !rsp_ready;
        rsp_next       = rsp_reg;
        op             = '0;
        fs_we          = 1'b0;
        fs_waddr       = MEM_AW'({k_reg, POS_W'(top)});
        fs_wdata       = pd_rdata;
        fs_re          = 1'b0;
        fs_raddr       = MEM_AW'({sel_heap, POS_W'(top_m1)});
        pd_we          = 1'b0;
        pd_waddr       = MEM_AW'({sel_heap, POS_W'(pcnt)});
        pd_re          = 1'b0;
        pd_raddr       = MEM_AW'({k_reg, POS_W'(i_reg)});

        unique case (state_reg)
            S_IDLE:
            begin
                if (req_valid)
                begin
                    h_next        = req.heap_type;
                    status_next   = ST_OK;
                    alloc_ok_next = 1'b0;
                    state_next    = S_RESP;
                    case (req.req_type)
                        REQ_ALLOC:
                        begin
                            if (!present)
                            begin
                                status_next = ST_ABSENT;
                            end
                            else if (top == '0)
                            begin
                                status_next = ST_EMPTY;
                            end
                            else
                            begin
                                op.top_dec    = 1'b1;
                                fs_re         = 1'b1;
                                alloc_ok_next = 1'b1;
                                use_mem_next  = (top_m1 >= lo);
                                pos_next      = POS_W'(top_m1);
                            end
                        end
                        REQ_RELEASE:
                        begin
                            if (!present)
                            begin
                                status_next = ST_ABSENT;
                            end
                            else if (pend_full)
                            begin
                                status_next = ST_PEND_FULL;
                            end
                            else
                            begin
                                pd_we       = 1'b1;
                                op.pcnt_inc = 1'b1;
                            end
                        end
                        REQ_FLUSH:
                        begin
                            k_next     = '0;
                            i_next     = '0;
                            ovf_next   = 1'b0;
                            state_next = S_FL_RD;
                        end
                        default:
                        begin
                            status_next = ST_OK;
                        end
                    endcase
                end
            end
            S_RESP:
            begin
                if (!rsp_valid_reg || rsp_ready)
                begin
                    rsp_valid_next       = 1'b1;
                    rsp_next.status      = status_reg;
                    rsp_next.alloc_index = !alloc_ok_reg ? '0 :
                                           (use_mem_reg ? fs_rdata : IDX_W'(pos_reg));
                    rsp_next.free_count  = present ? CNT_OUT_W'(top) : '0;
                    state_next           = S_IDLE;
                end
            end
            S_FL_RD:
            begin
                if (heap_done)
                begin
                    // The pending list is emptied even when entries were dropped.
                    op.pcnt_clr = 1'b1;
                    i_next      = '0;
                    ovf_next    = ovf_reg || ovf_hit;
                    if (k_reg == HW'(NUM_HEAPS - 1))
                    begin
                        status_next   = (ovf_reg || ovf_hit) ? ST_OVERFLOW : ST_OK;
                        alloc_ok_next = 1'b0;
                        state_next    = S_RESP;
                    end
                    else
                    begin
                        k_next = k_reg + HW'(1);
                    end
                end
                else
                begin
                    pd_re      = 1'b1;
                    state_next = S_FL_WR;
                end
            end
            S_FL_WR:
            begin
                fs_we      = 1'b1;
                op.top_inc = 1'b1;
                i_next     = i_reg + CNT_W'(1);
                state_next = S_FL_RD;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            rsp_valid_reg <= 1'b0;
            k_reg         <= '0;
            i_reg         <= '0;
            ovf_reg       <= 1'b0;
            alloc_ok_reg  <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            rsp_valid_reg <= rsp_valid_next;
            k_reg         <= k_next;
            i_reg         <= i_next;
            ovf_reg       <= ovf_next;
            alloc_ok_reg  <= alloc_ok_next;
        end
    end

    always_ff @(posedge clk)
    begin
        h_reg       <= h_next;
        status_reg  <= status_next;
        use_mem_reg <= use_mem_next;
        pos_reg     <= pos_next;
        rsp_reg     <= rsp_next;
    end

    // An accepted request leaves the control busy, so requests are never accepted back to back.
    `DFIA_ASSERT_NEXT(a_busy_after_accept, req_valid && req_ready, !req_ready,
        "request accepted back to back")
    // The flush never writes past the end of a free stack region.
    `DFIA_ASSERT_IMPL(a_flush_fits, state_reg == S_FL_WR, !top_full,
        "flush write beyond free stack capacity")
    // The selected heap's pending list never grows beyond its region.
    `DFIA_ASSERT_ALWAYS(a_pend_bound, !(32'(pcnt) > MAX_DESC),
        "pending count beyond capacity")

endmodule

[rtl/dfia_ram.sv]
// ----------------------------------------------------------------------------
// dfia_ram
// Generic simple dual port RAM: one write port, one registered read port.
// ----------------------------------------------------------------------------
module dfia_ram #(
    parameter int WIDTH = 10,
    parameter int DEPTH = 4096,
    parameter int AW    = $clog2(DEPTH)
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic             re,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

[rtl/dfia_heap_tbl.sv]
// ----------------------------------------------------------------------------
// dfia_heap_tbl
// Per-heap size, free stack depth, fill mark and pending count registers.
// ----------------------------------------------------------------------------
module dfia_heap_tbl #(
    parameter int NUM_HEAPS = dfia_pkg::NUM_HEAPS_DEF,
    parameter int MAX_DESC  = dfia_pkg::MAX_DESC_DEF,
    parameter int HW        = (NUM_HEAPS > 1) ? $clog2(NUM_HEAPS) : 1,
    parameter int CNT_W     = $clog2(MAX_DESC + 1)
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                cfg_we,
    input  logic [dfia_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [dfia_pkg::CFG_DATA_W-1:0]     cfg_data,
    input  logic [HW-1:0]                       sel_heap,
    input  logic                                sel_ok,
    input  dfia_pkg::heap_op_t                  op,
    output logic                                present,
    output logic [CNT_W-1:0]                    top,
    output logic [CNT_W-1:0]                    lo,
    output logic [CNT_W-1:0]                    pcnt
);

    import dfia_pkg::*;

    logic [CFG_DATA_W-1:0] size_reg [NUM_HEAPS];
    logic [CNT_W-1:0]      top_reg  [NUM_HEAPS];
    logic [CNT_W-1:0]      lo_reg   [NUM_HEAPS];
    logic [CNT_W-1:0]      pcnt_reg [NUM_HEAPS];

    logic             cfg_hit;
    logic [HW-1:0]    cfg_heap;
    logic [CNT_W-1:0] fill_n;

    assign cfg_hit  = cfg_we && (32'(cfg_index) < NUM_HEAPS);
    assign cfg_heap = HW'(cfg_index);
    assign fill_n   = (32'(cfg_data) > MAX_DESC) ? CNT_W'(MAX_DESC) : CNT_W'(cfg_data);

    assign present = sel_ok && (size_reg[sel_heap] != '0);
    assign top     = top_reg[sel_heap];
    assign lo      = lo_reg[sel_heap];
    assign pcnt    = pcnt_reg[sel_heap];

    // Entries of a free stack below the fill mark were never overwritten since
    // the last size write; their index is their own position, not RAM data.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int h = 0; h < NUM_HEAPS; h++)
            begin
                size_reg[h] <= '0;
                top_reg[h]  <= '0;
                lo_reg[h]   <= '0;
                pcnt_reg[h] <= '0;
            end
        end
        else if (cfg_hit)
        begin
            size_reg[cfg_heap] <= cfg_data;
            top_reg[cfg_heap]  <= fill_n;
            lo_reg[cfg_heap]   <= fill_n;
            pcnt_reg[cfg_heap] <= '0;
        end
        else
        begin
            if (op.top_dec)
            begin
                top_reg[sel_heap] <= top_reg[sel_heap] - CNT_W'(1);
            end
            if (op.top_inc)
            begin
                top_reg[sel_heap] <= top_reg[sel_heap] + CNT_W'(1);
                if (top_reg[sel_heap] < lo_reg[sel_heap])
                begin
                    lo_reg[sel_heap] <= top_reg[sel_heap];
                end
            end
            if (op.pcnt_inc)
            begin
                pcnt_reg[sel_heap] <= pcnt_reg[sel_heap] + CNT_W'(1);
            end
            if (op.pcnt_clr)
            begin
                pcnt_reg[sel_heap] <= '0;
            end
        end
    end

endmodule

[bench/deferred_free_index_allocator_unit_test.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Deferred free index allocator testbench
// Drives allocate, release, flush and unknown request beats into the unit
// under several heap size settings and idling mixes. Every result beat is
// checked field by field against the value given in the directed script
// or against a predictor of the free stacks and pending lists held here.
// ----------------------------------------------------------------------------
module deferred_free_index_allocator_unit_test;
    import dfia_pkg::*;

    localparam int HEAPS = NUM_HEAPS_DEF;
    localparam int SLOTS = MAX_DESC_DEF;
    localparam int RANDOM_PER_PHASE = 100;
    localparam int HOLD_OFF_CYCLES = 400;
    localparam int PENDING_FILL = SLOTS + 2;

    localparam logic [REQ_W-1:0] REQ_UNKNOWN = 2'd3;

    localparam logic [CFG_IDX_W-1:0] REG_HEAP0 = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_HEAP1 = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_HEAP2 = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_HEAP3 = 2'd3;

    // One directed step: a size register write, or a request whose result is
    // either given here or left to the predictor.
    typedef struct packed {
        logic                  is_cfg;
        logic [1:0]            target;   // register index or heap number
        logic [CFG_DATA_W-1:0] value;    // size or release index
        logic [REQ_W-1:0]      op;
        logic                  typed;
        logic [STATUS_W-1:0]   st;
        logic [IDX_W-1:0]      idx;
        logic [CNT_OUT_W-1:0]  cnt;
    } script_row_t;

    typedef struct packed {
        logic typed;
        rsp_t want;
    } req_note_t;

    localparam int SCRIPT_LEN = 26;
    script_row_t script [SCRIPT_LEN] = '{
        '{1'b0, 2'd0, 11'd0,    REQ_ALLOC,   1'b1, ST_ABSENT,   10'd0,    11'd0},
        '{1'b0, 2'd1, 11'd5,    REQ_RELEASE, 1'b1, ST_ABSENT,   10'd0,    11'd0},
        '{1'b0, 2'd0, 11'd0,    REQ_FLUSH,   1'b1, ST_OK,       10'd0,    11'd0},
        '{1'b0, 2'd2, 11'd1023, REQ_UNKNOWN, 1'b1, ST_OK,       10'd0,    11'd0},
        '{1'b1, REG_HEAP0, 11'd2,    REQ_ALLOC, 1'b0, ST_OK,    10'd0,    11'd0},
        '{1'b1, REG_HEAP1, 11'd0,    REQ_ALLOC, 1'b0, ST_OK,    10'd0,    11'd0},
        '{1'b1, REG_HEAP2, 11'd1024, REQ_ALLOC, 1'b0, ST_OK,    10'd0,    11'd0},
        '{1'b1, REG_HEAP3, 11'd2047, REQ_ALLOC, 1'b0, ST_OK,    10'd0,    11'd0},
        '{1'b0, 2'd0, 11'd0,    REQ_ALLOC,   1'b1, ST_OK,       10'd1,    11'd1},
        '{1'b0, 2'd0, 11'd0,    REQ_ALLOC,   1'b1, ST_OK,       10'd0,    11'd0},
        '{1'b0, 2'd0, 11'd0,    REQ_ALLOC,   1'b1, ST_EMPTY,    10'd0,    11'd0},
        '{1'b0, 2'd0, 11'd1023, REQ_RELEASE, 1'b1, ST_OK,       10'd0,    11'd0},
        '{1'b0, 2'd0, 11'd0,    REQ_RELEASE, 1'b1, ST_OK,       10'd0,    11'd0},
        '{1'b0, 2'd1, 11'd0,    REQ_ALLOC,   1'b1, ST_ABSENT,   10'd0,    11'd0},
        '{1'b0, 2'd2, 11'd0,    REQ_ALLOC,   1'b1, ST_OK,       10'd1023, 11'd1023},
        '{1'b0, 2'd3, 11'd0,    REQ_ALLOC,   1'b1, ST_OK,       10'd1023, 11'd1023},
        '{1'b0, 2'd2, 11'd7,    REQ_RELEASE, 1'b0, ST_OK,       10'd0,    11'd0},
        '{1'b0, 2'd2, 11'd9,    REQ_RELEASE, 1'b0, ST_OK,       10'd0,    11'd0},
        '{1'b0, 2'd3, 11'h2AA,  REQ_RELEASE, 1'b0, ST_OK,       10'd0,    11'd0},
        '{1'b0, 2'd0, 11'd0,    REQ_FLUSH,   1'b1, ST_OVERFLOW, 10'd0,    11'd2},
        '{1'b0, 2'd0, 11'd0,    REQ_ALLOC,   1'b0, ST_OK,       10'd0,    11'd0},
        '{1'b0, 2'd0, 11'd0,    REQ_ALLOC,   1'b0, ST_OK,       10'd0,    11'd0},
        '{1'b0, 2'd2, 11'd0,    REQ_ALLOC,   1'b0, ST_OK,       10'd0,    11'd0},
        '{1'b0, 2'd3, 11'h155,  REQ_UNKNOWN, 1'b1, ST_OK,       10'd0,    11'd1024},
        '{1'b0, 2'd1, 11'h3FF,  REQ_RELEASE, 1'b1, ST_ABSENT,   10'd0,    11'd0},
        '{1'b0, 2'd2, 11'd0,    REQ_FLUSH,   1'b0, ST_OK,       10'd0,    11'd0}
    };

    logic                  clk = 1'b0;
    logic                  rst_n = 1'b0;
    logic                  cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_data = '0;
    logic                  req_valid = 1'b0;
    logic                  req_ready;
    req_t                  req = '0;
    logic                  rsp_valid;
    logic                  rsp_ready = 1'b0;
    rsp_t                  rsp;

    // Predicted heap state.
    logic [CFG_DATA_W-1:0] size_reg [HEAPS];
    logic [IDX_W-1:0]      stack_mem [HEAPS][SLOTS];
    int unsigned           stack_depth [HEAPS];
    logic [IDX_W-1:0]      deferred_mem [HEAPS][SLOTS];
    int unsigned           deferred_cnt [HEAPS];
    logic [IDX_W-1:0]      in_use [HEAPS][$];

    rsp_t        answers_due [$];
    req_note_t   req_notes [$];
    req_note_t   accepted_note;
    rsp_t        predicted;
    int unsigned mismatches = 0;
    int unsigned send_idle_pct = 0;
    int unsigned rsp_stall_pct = 0;
    logic        hold_off_req = 1'b0;

    deferred_free_index_allocator_unit dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .req_valid (req_valid),
        .req_ready (req_ready),
        .req       (req),
        .rsp_valid (rsp_valid),
        .rsp_ready (rsp_ready),
        .rsp       (rsp)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    function automatic logic heap_live(int unsigned h);
        return (h < HEAPS) && (size_reg[h] != '0);
    endfunction

    function automatic void load_size(int unsigned k, logic [CFG_DATA_W-1:0] v);
        int unsigned n;
        size_reg[k] = v;
        n = (v > SLOTS) ? SLOTS : v;
        for (int unsigned i = 0; i < n; i++)
            stack_mem[k][i] = IDX_W'(i);
        stack_depth[k] = n;
        deferred_cnt[k] = 0;
        in_use[k].delete();
    endfunction

    function automatic rsp_t serve_request(req_t r);
        rsp_t        a;
        int unsigned h;
        a.status = ST_OK;
        a.alloc_index = '0;
        h = r.heap_type;
        case (r.req_type)
            REQ_ALLOC:
            begin
                if (!heap_live(h))
                    a.status = ST_ABSENT;
                else if (stack_depth[h] == 0)
                    a.status = ST_EMPTY;
                else
                begin
                    stack_depth[h]--;
                    a.alloc_index = stack_mem[h][stack_depth[h]];
                    in_use[h].insert(in_use[h].size(), a.alloc_index);
                end
            end
            REQ_RELEASE:
            begin
                if (!heap_live(h))
                    a.status = ST_ABSENT;
                else if (deferred_cnt[h] >= SLOTS)
                    a.status = ST_PEND_FULL;
                else
                begin
                    deferred_mem[h][deferred_cnt[h]] = r.release_index;
                    deferred_cnt[h]++;
                end
            end
            REQ_FLUSH:
            begin
                for (int unsigned k = 0; k < HEAPS; k++)
                begin
                    if (heap_live(k))
                    begin
                        // Entries that do not fit are lost, but the list still empties.
                        for (int unsigned i = 0; i < deferred_cnt[k]; i++)
                        begin
                            if (stack_depth[k] >= SLOTS)
                            begin
                                a.status = ST_OVERFLOW;
                                break;
                            end
                            stack_mem[k][stack_depth[k]] = deferred_mem[k][i];
                            stack_depth[k]++;
                        end
                        deferred_cnt[k] = 0;
                    end
                end
            end
            default:
            begin
            end
        endcase
        a.free_count = heap_live(h) ? CNT_OUT_W'(stack_depth[h]) : '0;
        return a;
    endfunction

    // Mostly allocate and release, with released indices usually taken from
    // those handed out earlier, so that flushes recycle real slots.
    function automatic req_t random_request();
        req_t        r;
        int unsigned h;
        int unsigned pick;
        int unsigned j;
        h = $urandom_range(HEAPS - 1);
        r.heap_type = HEAP_W'(h);
        r.release_index = IDX_W'($urandom_range(SLOTS - 1));
        pick = $urandom_range(99);
        if (pick < 42)
            r.req_type = REQ_ALLOC;
        else if (pick < 82)
        begin
            r.req_type = REQ_RELEASE;
            if (in_use[h].size() != 0 && $urandom_range(9) < 7)
            begin
                j = $urandom_range(in_use[h].size() - 1);
                r.release_index = in_use[h][j];
                in_use[h].delete(j);
            end
        end
        else if (pick < 95)
            r.req_type = REQ_FLUSH;
        else
            r.req_type = REQ_UNKNOWN;
        return r;
    endfunction

    function automatic logic [CFG_DATA_W-1:0] random_size();
        case ($urandom_range(9))
            0: return '0;
            1: return CFG_DATA_W'(SLOTS);
            2: return CFG_DATA_W'($urandom_range(2047, SLOTS + 1));
            3: return 11'd1;
            default: return CFG_DATA_W'($urandom_range(24, 2));
        endcase
    endfunction

    task automatic report_mismatch(input string what, input int got, input int want);
        $display("%0t: %s mismatch: got %0d, expected %0d", $time, what, got, want);
        mismatches++;
    endtask

    task automatic check_result(input rsp_t got);
        rsp_t want;
        if (answers_due.size() == 0)
        begin
            report_mismatch("unrequested result, status", got.status, 0);
            return;
        end
        want = answers_due.pop_front();
        if (got.status !== want.status)
            report_mismatch("status", got.status, want.status);
        if (got.alloc_index !== want.alloc_index)
            report_mismatch("alloc_index", got.alloc_index, want.alloc_index);
        if (got.free_count !== want.free_count)
            report_mismatch("free_count", got.free_count, want.free_count);
    endtask

    // Request and result beats are both taken at the clock edge.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (rsp_valid && rsp_ready)
                check_result(rsp);
            if (req_valid && req_ready)
            begin
                accepted_note = req_notes.pop_front();
                predicted = serve_request(req);
                if (accepted_note.typed)
                    predicted = accepted_note.want;
                answers_due.insert(answers_due.size(), predicted);
            end
        end
    end

    task automatic send_request(input req_t r, input logic typed, input rsp_t want);
        req_note_t note;
        while ($urandom_range(99) < send_idle_pct)
        begin
            req_valid <= 1'b0;
            @(posedge clk);
        end
        note.typed = typed;
        note.want = want;
        req_notes.insert(req_notes.size(), note);
        req_valid <= 1'b1;
        req <= r;
        do
            @(posedge clk);
        while (!req_ready);
    endtask

    task automatic drain_results();
        req_valid <= 1'b0;
        do
            @(posedge clk);
        while (answers_due.size() != 0);
        repeat (4) @(posedge clk);
    endtask

    task automatic write_size(input logic [CFG_IDX_W-1:0] sel,
                              input logic [CFG_DATA_W-1:0] v);
        cfg_we <= 1'b1;
        cfg_index <= sel;
        cfg_data <= v;
        @(posedge clk);
        cfg_we <= 1'b0;
        load_size(sel, v);
        @(posedge clk);
    endtask

    // Result receiver; a long hold-off lets the unit back up into its input.
    initial
    begin
        wait (rst_n);
        forever
        begin
            @(posedge clk);
            if (hold_off_req)
            begin
                hold_off_req = 1'b0;
                rsp_ready <= 1'b0;
                repeat (HOLD_OFF_CYCLES) @(posedge clk);
            end
            rsp_ready <= ($urandom_range(99) >= rsp_stall_pct);
        end
    end

    initial
    begin
        #5_000_000;
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

    initial
    begin
        req_t   item;
        rsp_t   want;
        int     s;
        int     phase;
        int     n;
        int     k;
        for (k = 0; k < HEAPS; k++)
        begin
            size_reg[k] = '0;
            stack_depth[k] = 0;
            deferred_cnt[k] = 0;
        end
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        for (s = 0; s < SCRIPT_LEN; s++)
        begin
            if (script[s].is_cfg)
            begin
                drain_results();
                write_size(script[s].target, script[s].value);
            end
            else
            begin
                item.req_type = script[s].op;
                item.heap_type = script[s].target;
                item.release_index = script[s].value[IDX_W-1:0];
                want.status = script[s].st;
                want.alloc_index = script[s].idx;
                want.free_count = script[s].cnt;
                send_request(item, script[s].typed, want);
            end
        end

        for (phase = 0; phase < 4; phase++)
        begin
            drain_results();
            case (phase)
                0: begin send_idle_pct = 0;  rsp_stall_pct = 0;  end
                1: begin send_idle_pct = 81; rsp_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  rsp_stall_pct = 81; end
                default: begin send_idle_pct = 22; rsp_stall_pct = 22; end
            endcase
            for (k = 0; k < HEAPS; k++)
                write_size(CFG_IDX_W'(k), random_size());
            for (n = 0; n < RANDOM_PER_PHASE; n++)
            begin
                if (phase == 0 && n == 60)
                    hold_off_req = 1'b1;
                send_request(random_request(), 1'b0, '0);
            end
        end

        // Overfill one heap's pending list, then flush it into a stack that overflows.
        drain_results();
        write_size(REG_HEAP1, 11'd3);
        item.heap_type = 2'd1;
        for (n = 0; n < PENDING_FILL; n++)
        begin
            item.req_type = REQ_RELEASE;
            item.release_index = IDX_W'($urandom_range(SLOTS - 1));
            send_request(item, 1'b0, '0);
        end
        item.req_type = REQ_FLUSH;
        send_request(item, 1'b0, '0);
        item.req_type = REQ_ALLOC;
        repeat (5) send_request(item, 1'b0, '0);

        drain_results();
        repeat (20) @(posedge clk);
        if (mismatches == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule

[deferred_free_index_allocator_unit.f]
+incdir+rtl
rtl/dfia_pkg.sv
rtl/dfia_ram.sv
rtl/dfia_heap_tbl.sv
rtl/deferred_free_index_allocator_unit.sv
bench/deferred_free_index_allocator_unit_test.sv
